// ===== src/sha1_pkg.sv =====
// Package: SHA-1 hasher types, constants and round helpers
package sha1_pkg;

   localparam int ChainWords = 5;
   localparam int BlockWords = 16;
   localparam int CountBits  = 61;
   localparam int Rounds     = 80;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;

   localparam logic [7:0] PadMarker = 8'h80;
   localparam logic [5:0] LenPos    = 6'd56;

   localparam logic KindData   = 1'b0;
   localparam logic KindFinish = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic put_byte;      // write req byte at current position, count up
      logic put_pad;       // write pad byte (marker or zero) at current position
      logic pad_marker;    // pad byte is the 0x80 marker
      logic put_len;       // write bit length into words 14 and 15
      logic round_start;   // load round variables from chain
      logic round_step;    // run one round
      logic round_done;    // fold round variables into chain
      logic emit_load;     // latch digest words for output
      logic restart;       // back to initial chain and zero count
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic [5:0] pos;     // byte position within the block
      logic       last_round;
   } stat_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// ===== src/sha1_datapath.sv =====
// SHA-1 datapath: block store, byte count, chain words and the round unit
module sha1_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sha1_pkg::ctrl_type ctrl,
   input  logic [7:0]        data_byte,
   output sha1_pkg::stat_type stat,
   output logic [31:0]       dig_word [5]
);
   import sha1_pkg::*;

   logic [31:0]          blk_ff   [BlockWords];
   logic [31:0]          blk_in   [BlockWords];
   logic [31:0]          chain_ff [ChainWords];
   logic [31:0]          chain_in [ChainWords];
   logic [31:0]          rv_ff    [ChainWords];
   logic [31:0]          rv_in    [ChainWords];
   logic [CountBits-1:0] count_ff, count_in;
   logic [5:0]           pos_ff, pos_in;
   logic [6:0]           round_ff, round_in;
   logic [31:0]          dig_ff   [ChainWords];
   logic [31:0]          dig_in   [ChainWords];

   logic [5:0]  pos;
   logic [3:0]  wsel;
   logic [7:0]  wbyte;
   logic        wr;
   logic [31:0] w_new, wt, f, k, tmp, mix;

   // write position follows message bytes and pad bytes; count follows message bytes only
   assign pos  = pos_ff;
   assign wsel = pos[5:2];
   assign stat.pos        = pos;
   assign stat.last_round = (round_ff == 7'(Rounds - 1));

   // schedule word: w[t] is in slot t mod 16, renewed from round 16 on
   assign mix   = blk_ff[(round_ff[3:0] + 4'd13)] ^ blk_ff[(round_ff[3:0] + 4'd8)]
                ^ blk_ff[(round_ff[3:0] + 4'd2)] ^ blk_ff[round_ff[3:0]];
   assign w_new = rotl(mix, 1);
   assign wt    = (round_ff < 7'd16) ? blk_ff[round_ff[3:0]] : w_new;

   // round function and constant
   always_comb begin
      if (round_ff < 7'd20) begin
         f = (rv_ff[1] & rv_ff[2]) | (~rv_ff[1] & rv_ff[3]);
         k = 32'h5a827999;
      end else if (round_ff < 7'd40) begin
         f = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k = 32'h6ed9eba1;
      end else if (round_ff < 7'd60) begin
         f = (rv_ff[1] & rv_ff[2]) | (rv_ff[1] & rv_ff[3]) | (rv_ff[2] & rv_ff[3]);
         k = 32'h8f1bbcdc;
      end else begin
         f = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k = 32'hca62c1d6;
      end
      tmp = rotl(rv_ff[0], 5) + f + rv_ff[4] + k + wt;
   end

   // byte writes, length words and schedule updates
   assign wr    = ctrl.put_byte | ctrl.put_pad;
   assign wbyte = ctrl.put_byte ? data_byte : (ctrl.pad_marker ? PadMarker : 8'h00);

   always_comb begin
      blk_in = blk_ff;
      if (wr) begin
         case (pos[1:0])
            2'd0:    blk_in[wsel] = {wbyte, 24'h0};
            2'd1:    blk_in[wsel][23:16] = wbyte;
            2'd2:    blk_in[wsel][15:8]  = wbyte;
            default: blk_in[wsel][7:0]   = wbyte;
         endcase
      end
      if (ctrl.put_len) begin
         blk_in[14] = count_ff[60:29];
         blk_in[15] = {count_ff[28:0], 3'b000};
      end
      if (ctrl.round_step && round_ff >= 7'd16) begin
         blk_in[round_ff[3:0]] = w_new;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      rv_in    = rv_ff;
      dig_in   = dig_ff;
      if (ctrl.put_byte) count_in = count_ff + 1'b1;
      if (wr) pos_in = pos_ff + 1'b1;
      if (ctrl.round_start) begin
         rv_in    = chain_ff;
         round_in = '0;
      end
      if (ctrl.round_step) begin
         rv_in[4] = rv_ff[3];
         rv_in[3] = rv_ff[2];
         rv_in[2] = rotl(rv_ff[1], 30);
         rv_in[1] = rv_ff[0];
         rv_in[0] = tmp;
         round_in = round_ff + 1'b1;
      end
      if (ctrl.round_done) begin
         for (int i = 0; i < ChainWords; i++) chain_in[i] = chain_ff[i] + rv_ff[i];
      end
      // digest taken from the folded chain before it restarts
      if (ctrl.emit_load) dig_in = chain_in;
      if (ctrl.restart) begin
         chain_in = '{H0, H1, H2, H3, H4};
         count_in = '0;
         pos_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '{H0, H1, H2, H3, H4};
         count_ff <= '0;
         pos_ff   <= '0;
         round_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rv_ff  <= rv_in;
      dig_ff <= dig_in;
   end

   assign dig_word = dig_ff;

endmodule

// ===== src/sha1_control.sv =====
// SHA-1 controller: input handshake, padding sequence, rounds and digest output
module sha1_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               kind,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         word_index,
   output logic               last,
   output sha1_pkg::ctrl_type ctrl,
   input  sha1_pkg::stat_type stat
);
   import sha1_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MARK  = 7'b0000010,
      S_PAD   = 7'b0000100,
      S_LEN   = 7'b0001000,
      S_ROUND = 7'b0010000,
      S_FOLD  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        fin_ff, fin_in;     // block in flight is part of a finish
   logic        final_ff, final_in; // block in flight carries the length
   logic [2:0]  idx_ff, idx_in;
   logic        acc;

   assign req_ready  = (state_ff == S_IDLE);
   assign acc        = req_valid & req_ready;
   assign rsp_valid  = (state_ff == S_EMIT);
   assign word_index = idx_ff;
   assign last       = (idx_ff == 3'd4);

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      final_in = final_ff;
      idx_in   = idx_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (kind == KindData) begin
                  ctrl.put_byte = 1'b1;
                  if (stat.pos == 6'd63) begin
                     ctrl.round_start = 1'b1;
                     fin_in   = 1'b0;
                     state_in = S_ROUND;
                  end
               end else begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            // count is still the message length here
            ctrl.put_pad    = 1'b1;
            ctrl.pad_marker = 1'b1;
            fin_in = 1'b1;
            state_in = (stat.pos == 6'd63) ? S_LEN : S_PAD;
            if (stat.pos == 6'd63) begin
               ctrl.put_pad = 1'b1;
            end
         end
         S_PAD: begin
            // zero fill up to 56, or to the end of a tail block that has no room
            if (stat.pos == LenPos) begin
               state_in = S_LEN;
            end else begin
               ctrl.put_pad = 1'b1;
               if (stat.pos == 6'd63) state_in = S_LEN;
            end
         end
         S_LEN: begin
            // either the length block or a full tail block goes to the rounds
            ctrl.round_start = 1'b1;
            ctrl.put_len = (stat.pos == LenPos);
            final_in = (stat.pos == LenPos);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            ctrl.round_step = 1'b1;
            if (stat.last_round) state_in = S_FOLD;
         end
         S_FOLD: begin
            ctrl.round_done = 1'b1;
            if (!fin_ff) begin
               state_in = S_IDLE;
            end else if (final_ff) begin
               ctrl.emit_load = 1'b1;
               ctrl.restart   = 1'b1;
               idx_in   = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'd4) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_FOLD && fin_ff && final_ff) begin
         final_in = 1'b0;
      end
      if (state_ff == S_EMIT && rsp_ready && idx_ff == 3'd4) begin
         fin_in = 1'b0;
      end
   end

   // length write rides with the length-block start
   // (pad ends at 56; the length overwrites words 14 and 15)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
         final_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         final_ff <= final_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== src/sha1_byte_stream_hasher.sv =====
// SHA-1 byte stream hasher top level
//  channel | ports                          | direction
//  req     | req_valid/ready, kind, byte   | in, one message byte or finish per word
//  rsp     | rsp_valid/ready, digest, index | out, five digest words per finish
//  Data bytes are taken one per cycle while idle; the 64th byte of a block adds
//  80 rounds and a fold. A finish is accepted, then pad bytes go one per cycle,
//  with a pause at position 56; each block is compressed (start, 80 rounds,
//  fold), then five output words go one per cycle while rsp_ready is high.
//  Reset is synchronous; it restores the initial chain and a zero count.
//  Output stalls hold the block in its output state.
module sha1_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last
);
   import sha1_pkg::*;

   ctrl_type    ctrl;
   stat_type    stat;
   logic [31:0] dig [ChainWords];

   sha1_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .kind(req_kind),
      .rsp_valid, .rsp_ready, .word_index(rsp_word_index), .last(rsp_last),
      .ctrl, .stat
   );

   sha1_datapath u_dp (
      .clock, .reset, .ctrl, .data_byte(req_data_byte), .stat, .dig_word(dig)
   );

   assign rsp_digest_word = dig[rsp_word_index];

endmodule
